// ===== rtl/mep_pkg.sv =====
package mep_pkg;

    localparam int POS_W      = 10;   // pixel row / column
    localparam int CNT_W      = 11;   // row_count / column_count
    localparam int LIMIT_W    = 16;   // iteration_limit and iteration_count
    localparam int GLYPH_W    = 8;
    localparam int COLOUR_W   = 4;
    localparam int Z_W        = 32;   // fixed-point word for c and z
    localparam int PROD_W     = 64;   // full product of two Z_W words
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT       = 3'd0,
        CFG_COLUMN_COUNT    = 3'd1,
        CFG_ITERATION_LIMIT = 3'd2,
        CFG_INSIDE_GLYPH    = 3'd3,
        CFG_OUTSIDE_GLYPH   = 3'd4,
        CFG_INSIDE_COLOUR   = 3'd5,
        CFG_OUTSIDE_COLOUR  = 3'd6
    } cfg_reg_t;

    localparam logic [CNT_W-1:0]    RST_ROW_COUNT       = 11'd40;
    localparam logic [CNT_W-1:0]    RST_COLUMN_COUNT    = 11'd80;
    localparam logic [LIMIT_W-1:0]  RST_ITERATION_LIMIT = 16'd200;
    localparam logic [GLYPH_W-1:0]  RST_INSIDE_GLYPH    = 8'd35;
    localparam logic [GLYPH_W-1:0]  RST_OUTSIDE_GLYPH   = 8'd42;
    localparam logic [COLOUR_W-1:0] RST_INSIDE_COLOUR   = 4'd8;
    localparam logic [COLOUR_W-1:0] RST_OUTSIDE_COLOUR  = 4'd1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_MAP  = 3'd1,
        ST_MUL  = 3'd2,
        ST_STEP = 3'd3,
        ST_FIN  = 3'd4
    } state_t;

    // Clamp a wide signed value into the fixed-point word
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] z_max;
        logic signed [PROD_W-1:0] z_min;
        z_max = PROD_W'({1'b0, {(Z_W-1){1'b1}}});
        z_min = -z_max - PROD_W'(1);
        if (v > z_max)
            return {1'b0, {(Z_W-1){1'b1}}};
        else if (v < z_min)
            return {1'b1, {(Z_W-1){1'b0}}};
        else
            return v[Z_W-1:0];
    endfunction

endpackage

// ===== rtl/mep_map.sv =====
module mep_map #(
    parameter int FRAC_BITS = 28
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [mep_pkg::POS_W-1:0]            row,
    input  logic [mep_pkg::POS_W-1:0]            column,
    input  logic [mep_pkg::CNT_W-1:0]            rows,
    input  logic [mep_pkg::CNT_W-1:0]            cols,
    output logic signed [mep_pkg::Z_W-1:0]       cx,
    output logic signed [mep_pkg::Z_W-1:0]       cy,
    output logic                                 done
);

    // Quotient of pos * 2^(FRAC_BITS+1) / count, one bit per cycle, both axes together
    localparam int Q_W    = mep_pkg::POS_W + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(Q_W);
    localparam logic signed [mep_pkg::PROD_W-1:0] OFF_X =
        mep_pkg::PROD_W'(3) <<< (FRAC_BITS - 1);
    localparam logic signed [mep_pkg::PROD_W-1:0] OFF_Y =
        mep_pkg::PROD_W'(1) <<< FRAC_BITS;

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [mep_pkg::POS_W-1:0]     num_x_reg, num_y_reg;
    logic [mep_pkg::CNT_W-1:0]     rem_x_reg, rem_y_reg;
    logic [Q_W-1:0]                q_x_reg, q_y_reg;

    logic [mep_pkg::CNT_W:0]       trial_x, trial_y;
    logic                          ge_x, ge_y;
    logic [mep_pkg::CNT_W-1:0]     rem_x_next, rem_y_next;
    logic                          last_step;

    assign trial_x = {rem_x_reg, num_x_reg[mep_pkg::POS_W-1]};
    assign trial_y = {rem_y_reg, num_y_reg[mep_pkg::POS_W-1]};
    assign ge_x    = trial_x >= {1'b0, cols};
    assign ge_y    = trial_y >= {1'b0, rows};

    always_comb
    begin
        rem_x_next = ge_x ? mep_pkg::CNT_W'(trial_x - {1'b0, cols})
                          : trial_x[mep_pkg::CNT_W-1:0];
        rem_y_next = ge_y ? mep_pkg::CNT_W'(trial_y - {1'b0, rows})
                          : trial_y[mep_pkg::CNT_W-1:0];
    end

    assign last_step = (step_reg == STEP_W'(Q_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (last_step)
                    busy_reg <= 1'b0;
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Shift the numerator in MSB first; zeros follow once the position is used up
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_x_reg <= column;
            num_y_reg <= row;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_x_reg <= {num_x_reg[mep_pkg::POS_W-2:0], 1'b0};
            num_y_reg <= {num_y_reg[mep_pkg::POS_W-2:0], 1'b0};
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg   <= {q_x_reg[Q_W-2:0], ge_x};
            q_y_reg   <= {q_y_reg[Q_W-2:0], ge_y};
        end
    end

    assign cx   = mep_pkg::sat_z($signed(mep_pkg::PROD_W'(q_x_reg)) - OFF_X);
    assign cy   = mep_pkg::sat_z($signed(mep_pkg::PROD_W'(q_y_reg)) - OFF_Y);
    assign done = done_reg;

endmodule

// ===== rtl/mandelbrot_escape_pixel_core.sv =====
// Channel | Handshake                    | Payload
// --------+------------------------------+-----------------------------------------------
// in      | in_valid / in_stall          | pixel_row, pixel_column
// out     | out_valid / out_stall        | is_inside, glyph, colour, iteration_count, row_end
// cfg     | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// After accept, an item runs the divider in ST_MAP (FRAC_BITS + 11 quotient bits), then
// passes of ST_MUL and ST_STEP on the multipliers, and waits in ST_FIN for the output
// register; the passes run equal the final count, plus one on escape.
// Reset loads the default image size, limit, glyphs and colours; no item is in flight.
// in_stall is high from accept until the result moves to the output register, which
// holds it under out_stall while the next item is accepted.
module mandelbrot_escape_pixel_core #(
    parameter int MAX_DIM    = 1024,
    parameter int ITER_WIDTH = 16,
    parameter int FRAC_BITS  = 28
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [mep_pkg::POS_W-1:0]           pixel_row,
    input  logic [mep_pkg::POS_W-1:0]           pixel_column,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_inside,
    output logic [mep_pkg::GLYPH_W-1:0]         glyph,
    output logic [mep_pkg::COLOUR_W-1:0]        colour,
    output logic [mep_pkg::LIMIT_W-1:0]         iteration_count,
    output logic                                row_end
);

    localparam logic [mep_pkg::PROD_W:0] FOUR = (mep_pkg::PROD_W + 1)'(4) << (2 * FRAC_BITS);

    // configuration
    logic [mep_pkg::CNT_W-1:0]    row_count_reg, column_count_reg;
    logic [mep_pkg::LIMIT_W-1:0]  iteration_limit_reg;
    logic [mep_pkg::GLYPH_W-1:0]  inside_glyph_reg, outside_glyph_reg;
    logic [mep_pkg::COLOUR_W-1:0] inside_colour_reg, outside_colour_reg;

    // sequencer and datapath
    mep_pkg::state_t                  state_reg, state_next;
    logic signed [mep_pkg::Z_W-1:0]    zx_reg, zy_reg, cx_reg, cy_reg;
    logic signed [mep_pkg::PROD_W-1:0] sx_reg, sy_reg, p_reg;
    logic [ITER_WIDTH-1:0]             count_reg;
    logic                              row_end_reg;

    // output register
    logic                              out_valid_reg;
    logic                              is_inside_reg;
    logic [mep_pkg::GLYPH_W-1:0]       glyph_reg;
    logic [mep_pkg::COLOUR_W-1:0]      colour_reg;
    logic [mep_pkg::LIMIT_W-1:0]       out_count_reg;
    logic                              out_row_end_reg;

    logic [mep_pkg::CNT_W-1:0]         rows_eff, cols_eff;
    logic [ITER_WIDTH-1:0]             limit_w;
    logic                              accept, out_free;
    logic                              load_z, do_mul, do_step, load_out;
    logic signed [mep_pkg::Z_W-1:0]    map_cx, map_cy;
    logic                              map_done;

    logic [mep_pkg::PROD_W:0]          mag;
    logic                              escape;
    logic [ITER_WIDTH-1:0]             count_inc;
    logic                              step_done;
    logic signed [mep_pkg::PROD_W-1:0] sq_x, sq_y, prod_xy;
    logic signed [mep_pkg::PROD_W-1:0] nx_full, ny_full;
    logic signed [mep_pkg::Z_W-1:0]    zx_new, zy_new;
    logic                              inside_now;

    // zero counts act as one, oversized counts clamp to MAX_DIM
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = mep_pkg::CNT_W'(1);
        else if (32'(row_count_reg) > MAX_DIM)
            rows_eff = mep_pkg::CNT_W'(MAX_DIM);
        else
            rows_eff = row_count_reg;

        if (column_count_reg == '0)
            cols_eff = mep_pkg::CNT_W'(1);
        else if (32'(column_count_reg) > MAX_DIM)
            cols_eff = mep_pkg::CNT_W'(MAX_DIM);
        else
            cols_eff = column_count_reg;
    end

    assign limit_w   = ITER_WIDTH'(iteration_limit_reg);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg       <= mep_pkg::RST_ROW_COUNT;
            column_count_reg    <= mep_pkg::RST_COLUMN_COUNT;
            iteration_limit_reg <= mep_pkg::RST_ITERATION_LIMIT;
            inside_glyph_reg    <= mep_pkg::RST_INSIDE_GLYPH;
            outside_glyph_reg   <= mep_pkg::RST_OUTSIDE_GLYPH;
            inside_colour_reg   <= mep_pkg::RST_INSIDE_COLOUR;
            outside_colour_reg  <= mep_pkg::RST_OUTSIDE_COLOUR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mep_pkg::CFG_ROW_COUNT:       row_count_reg <= cfg_data[mep_pkg::CNT_W-1:0];
                mep_pkg::CFG_COLUMN_COUNT:    column_count_reg <= cfg_data[mep_pkg::CNT_W-1:0];
                mep_pkg::CFG_ITERATION_LIMIT: iteration_limit_reg <= cfg_data;
                mep_pkg::CFG_INSIDE_GLYPH:    inside_glyph_reg <= cfg_data[mep_pkg::GLYPH_W-1:0];
                mep_pkg::CFG_OUTSIDE_GLYPH:   outside_glyph_reg <= cfg_data[mep_pkg::GLYPH_W-1:0];
                mep_pkg::CFG_INSIDE_COLOUR:   inside_colour_reg <= cfg_data[mep_pkg::COLOUR_W-1:0];
                mep_pkg::CFG_OUTSIDE_COLOUR:  outside_colour_reg <= cfg_data[mep_pkg::COLOUR_W-1:0];
                default:                      ;
            endcase
        end
    end

    mep_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .row    (pixel_row),
        .column (pixel_column),
        .rows   (rows_eff),
        .cols   (cols_eff),
        .cx     (map_cx),
        .cy     (map_cy),
        .done   (map_done)
    );

    // one pass: multiply, then test and update
    assign sq_x    = zx_reg * zx_reg;
    assign sq_y    = zy_reg * zy_reg;
    assign prod_xy = zx_reg * zy_reg;

    assign mag       = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign escape    = mag >= FOUR;
    assign count_inc = count_reg + ITER_WIDTH'(1);
    assign step_done = escape || (count_inc >= limit_w);

    // floor to FRAC_BITS fraction bits; the doubling of zx*zy is folded into the shift
    assign nx_full = (sx_reg - sy_reg) >>> FRAC_BITS;
    assign ny_full = p_reg >>> (FRAC_BITS - 1);
    assign zx_new  = mep_pkg::sat_z(nx_full + mep_pkg::PROD_W'(cx_reg));
    assign zy_new  = mep_pkg::sat_z(ny_full + mep_pkg::PROD_W'(cy_reg));

    assign inside_now = (count_reg == limit_w);

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mep_pkg::ST_IDLE: if (accept)    state_next = mep_pkg::ST_MAP;
            mep_pkg::ST_MAP:  if (map_done)  state_next = mep_pkg::ST_MUL;
            mep_pkg::ST_MUL:                 state_next = mep_pkg::ST_STEP;
            mep_pkg::ST_STEP: state_next = step_done ? mep_pkg::ST_FIN : mep_pkg::ST_MUL;
            mep_pkg::ST_FIN:  if (out_free)  state_next = mep_pkg::ST_IDLE;
            default:                         state_next = mep_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        load_z   = 1'b0;
        do_mul   = 1'b0;
        do_step  = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            mep_pkg::ST_IDLE: in_stall = 1'b0;
            mep_pkg::ST_MAP:  load_z   = map_done;
            mep_pkg::ST_MUL:  do_mul   = 1'b1;
            mep_pkg::ST_STEP: do_step  = 1'b1;
            mep_pkg::ST_FIN:  load_out = out_free;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mep_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            row_end_reg <= ({1'b0, pixel_column} == cols_eff - mep_pkg::CNT_W'(1));

        if (load_z)
        begin
            cx_reg    <= map_cx;
            cy_reg    <= map_cy;
            zx_reg    <= '0;
            zy_reg    <= '0;
            count_reg <= '0;
        end
        else if (do_step && !escape)
        begin
            // escape leaves the counter alone
            count_reg <= count_inc;
            if (!step_done)
            begin
                zx_reg <= zx_new;
                zy_reg <= zy_new;
            end
        end

        if (do_mul)
        begin
            sx_reg <= sq_x;
            sy_reg <= sq_y;
            p_reg  <= prod_xy;
        end

        if (load_out)
        begin
            is_inside_reg   <= inside_now;
            glyph_reg       <= inside_now ? inside_glyph_reg : outside_glyph_reg;
            colour_reg      <= inside_now ? inside_colour_reg : outside_colour_reg;
            out_count_reg   <= mep_pkg::LIMIT_W'(count_reg);
            out_row_end_reg <= row_end_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign is_inside       = is_inside_reg;
    assign glyph           = glyph_reg;
    assign colour          = colour_reg;
    assign iteration_count = out_count_reg;
    assign row_end         = out_row_end_reg;

    a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mep_pkg::ST_MAP))
        else $error("accepted item did not start mapping");

    a_map_done_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        map_done |-> (state_reg == mep_pkg::ST_MAP))
        else $error("divider finished outside the mapping phase");

    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mep_pkg::ST_MUL) |-> ((count_reg < limit_w) || (count_reg == '0)))
        else $error("iteration ran past the limit");

    a_inside_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (is_inside_reg == (out_count_reg == mep_pkg::LIMIT_W'(limit_w))))
        else $error("inside flag disagrees with the count");

endmodule

// ===== test/mandelbrot_escape_pixel_core_test.sv =====
module mandelbrot_escape_pixel_core_test;

    import mep_pkg::*;

    localparam int FRAC          = 28;
    localparam int MAX_DIM       = 1024;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 48;
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 10;

    localparam longint Z_MAX = (longint'(1) <<< 31) - 1;
    localparam longint Z_MIN = -(longint'(1) <<< 31);
    localparam longint ONE   = longint'(1) <<< FRAC;
    localparam logic [64:0] ESCAPE_MAG = 65'd4 << (2 * FRAC);

    // index beyond the register list; writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct packed {
        logic                is_inside;
        logic [GLYPH_W-1:0]  glyph;
        logic [COLOUR_W-1:0] colour;
        logic [LIMIT_W-1:0]  count;
        logic                row_end;
    } pixel_result_t;

    typedef enum logic [0:0] {
        STEP_PIXEL = 1'b0,
        STEP_REG   = 1'b1
    } step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [POS_W-1:0]       row;
        logic [POS_W-1:0]       column;
        logic                   typed;
        pixel_result_t          result;
    } step_t;

    typedef enum logic [1:0] {
        STALL_NONE     = 2'd0,
        STALL_COIN     = 2'd1,
        STALL_RUNS     = 2'd2,
        STALL_PERIODIC = 2'd3
    } stall_mode_t;

    localparam pixel_result_t NO_CHECK = '0;
    localparam int PLAN_LEN = 44;

    localparam step_t PLAN [PLAN_LEN] = '{
        // default image: corner, centre, far corners, row ends
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd0, 1'b1, '{1'b0, 8'd42, 4'd1, 16'd2, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd20, 10'd60, 1'b1,
          '{1'b1, 8'd35, 4'd8, 16'd200, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd1023, 10'd1023, 1'b1,
          '{1'b0, 8'd42, 4'd1, 16'd1, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd1023, 1'b1,
          '{1'b0, 8'd42, 4'd1, 16'd1, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd1023, 10'd0, 1'b1,
          '{1'b0, 8'd42, 4'd1, 16'd1, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd20, 10'd79, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd39, 10'd79, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd10, 10'd40, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd30, 10'd20, 1'b0, NO_CHECK},
        // zero limit: always outside with a count of one; limit of one: inside with a count of one
        '{STEP_REG, CFG_ITERATION_LIMIT, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd20, 10'd60, 1'b1,
          '{1'b0, 8'd42, 4'd1, 16'd1, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd0, 1'b1, '{1'b0, 8'd42, 4'd1, 16'd1, 1'b0}},
        '{STEP_REG, CFG_ITERATION_LIMIT, 16'd1, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd20, 10'd60, 1'b1,
          '{1'b1, 8'd35, 4'd8, 16'd1, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd0, 1'b1, '{1'b1, 8'd35, 4'd8, 16'd1, 1'b0}},
        // top glyph and colour codes, longest limit
        '{STEP_REG, CFG_INSIDE_GLYPH, 16'd255, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_OUTSIDE_GLYPH, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_INSIDE_COLOUR, 16'd15, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_OUTSIDE_COLOUR, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_ITERATION_LIMIT, 16'hFFFF, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd20, 10'd60, 1'b1,
          '{1'b1, 8'd255, 4'd15, 16'd65535, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd1023, 10'd1023, 1'b1,
          '{1'b0, 8'd0, 4'd0, 16'd1, 1'b0}},
        // zero counts act as one
        '{STEP_REG, CFG_INSIDE_GLYPH, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_OUTSIDE_GLYPH, 16'd255, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_INSIDE_COLOUR, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_OUTSIDE_COLOUR, 16'd15, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_ITERATION_LIMIT, 16'd200, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_COLUMN_COUNT, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd0, 1'b1,
          '{1'b0, 8'd255, 4'd15, 16'd2, 1'b1}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd1, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd1, 10'd0, 1'b0, NO_CHECK},
        // oversized counts clip to the largest image
        '{STEP_REG, CFG_ROW_COUNT, 16'd2047, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_COLUMN_COUNT, 16'd2047, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_ITERATION_LIMIT, 16'd50, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd512, 10'd768, 1'b1,
          '{1'b1, 8'd0, 4'd0, 16'd50, 1'b0}},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd1023, 10'd1023, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd0, 10'd0, 1'b0, NO_CHECK},
        // upper data bits are dropped by the registers
        '{STEP_REG, CFG_ROW_COUNT, 16'hFC00, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_COLUMN_COUNT, 16'hFC00, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_REG, CFG_SPARE_INDEX, 16'hFFFF, 10'd0, 10'd0, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd1023, 10'd1023, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd256, 10'd512, 1'b0, NO_CHECK},
        '{STEP_PIXEL, CFG_ROW_COUNT, 16'd0, 10'd5, 10'd1, 1'b0, NO_CHECK}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [POS_W-1:0]      pixel_row = '0;
    logic [POS_W-1:0]      pixel_column = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_inside;
    logic [GLYPH_W-1:0]    glyph;
    logic [COLOUR_W-1:0]   colour;
    logic [LIMIT_W-1:0]    iteration_count;
    logic                  row_end;

    // register image held by the testbench
    logic [CNT_W-1:0]      row_count_q       = RST_ROW_COUNT;
    logic [CNT_W-1:0]      column_count_q    = RST_COLUMN_COUNT;
    logic [LIMIT_W-1:0]    iteration_limit_q = RST_ITERATION_LIMIT;
    logic [GLYPH_W-1:0]    inside_glyph_q    = RST_INSIDE_GLYPH;
    logic [GLYPH_W-1:0]    outside_glyph_q   = RST_OUTSIDE_GLYPH;
    logic [COLOUR_W-1:0]   inside_colour_q   = RST_INSIDE_COLOUR;
    logic [COLOUR_W-1:0]   outside_colour_q  = RST_OUTSIDE_COLOUR;

    pixel_result_t pending_pixels [$];

    int bad_results   = 0;
    int results_seen  = 0;
    int inside_seen   = 0;
    int deepest_count = 0;
    int items_sent    = 0;
    int reg_writes    = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;

    mandelbrot_escape_pixel_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_row       (pixel_row),
        .pixel_column    (pixel_column),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .is_inside       (is_inside),
        .glyph           (glyph),
        .colour          (colour),
        .iteration_count (iteration_count),
        .row_end         (row_end)
    );

    always #6 clk = ~clk;

    function automatic int effective_count(input logic [CNT_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_DIM)
            return MAX_DIM;
        return int'(n);
    endfunction

    function automatic longint clamp_z(input longint v);
        if (v > Z_MAX)
            return Z_MAX;
        if (v < Z_MIN)
            return Z_MIN;
        return v;
    endfunction

    function automatic longint map_axis(input logic [POS_W-1:0] pos, input int n,
                                        input longint offset);
        longint unsigned num;
        num = 64'(pos) << (FRAC + 1);
        return clamp_z(longint'(num / 64'(n)) - offset);
    endfunction

    function automatic pixel_result_t escape_pixel(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
        int                 rows;
        int                 cols;
        longint             cx;
        longint             cy;
        longint             zx;
        longint             zy;
        longint             nx;
        longint             ny;
        longint unsigned    sx;
        longint unsigned    sy;
        logic [64:0]        mag;
        logic [LIMIT_W-1:0] count;
        pixel_result_t      res;
        rows = effective_count(row_count_q);
        cols = effective_count(column_count_q);
        cx = map_axis(c, cols, 3 * (ONE >>> 1));
        cy = map_axis(r, rows, ONE);
        zx = 0;
        zy = 0;
        count = '0;
        while (1)
        begin
            sx = (zx < 0) ? -zx : zx;
            sy = (zy < 0) ? -zy : zy;
            sx = sx * sx;
            sy = sy * sy;
            mag = {1'b0, sx} + {1'b0, sy};
            if (mag >= ESCAPE_MAG)
                break;
            // count before the limit test; escape leaves it alone
            count = count + 1'b1;
            if (count >= iteration_limit_q)
                break;
            nx = (longint'(sx) - longint'(sy)) >>> FRAC;
            ny = (2 * zx * zy) >>> FRAC;
            zx = clamp_z(nx + cx);
            zy = clamp_z(ny + cy);
        end
        res.is_inside = (count == iteration_limit_q);
        res.glyph     = res.is_inside ? inside_glyph_q : outside_glyph_q;
        res.colour    = res.is_inside ? inside_colour_q : outside_colour_q;
        res.count     = count;
        res.row_end   = (int'(c) == cols - 1);
        return res;
    endfunction

    // idle for a random gap before some bursts; hold the item until accepted, then log what it should produce
    task automatic send_pixel(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                              input logic use_typed, input pixel_result_t typed_res);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        pixel_row    <= r;
        pixel_column <= c;
        do @(posedge clk); while (in_stall);
        pending_pixels.push_back(use_typed ? typed_res : escape_pixel(r, c));
        items_sent++;
    endtask

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ROW_COUNT:       row_count_q       = data[CNT_W-1:0];
            CFG_COLUMN_COUNT:    column_count_q    = data[CNT_W-1:0];
            CFG_ITERATION_LIMIT: iteration_limit_q = data[LIMIT_W-1:0];
            CFG_INSIDE_GLYPH:    inside_glyph_q    = data[GLYPH_W-1:0];
            CFG_OUTSIDE_GLYPH:   outside_glyph_q   = data[GLYPH_W-1:0];
            CFG_INSIDE_COLOUR:   inside_colour_q   = data[COLOUR_W-1:0];
            CFG_OUTSIDE_COLOUR:  outside_colour_q  = data[COLOUR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver stall pattern, independent of the sender
    always @(posedge clk)
    begin
        logic stall_next;
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE: stall_next = 1'b0;
            STALL_COIN: stall_next = ($urandom_range(0, 1) == 1);
            STALL_RUNS:
            begin
                if (run_left == 0)
                begin
                    stall_next = ~out_stall;
                    run_left   = $urandom_range(1, 20);
                end
                else
                begin
                    stall_next = out_stall;
                    run_left--;
                end
            end
            default: stall_next = ((mode_left % 5) < 2);
        endcase
        out_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{is_inside, glyph, colour, iteration_count, row_end};
            results_seen++;
            if (got.is_inside)
                inside_seen++;
            if (int'(got.count) > deepest_count)
                deepest_count = int'(got.count);
            if (pending_pixels.size() == 0)
            begin
                bad_results++;
                if (bad_results <= REPORT_LIMIT)
                    $display("unexpected result: inside=%0d glyph=%0d colour=%0d count=%0d end=%0d",
                             got.is_inside, got.glyph, got.colour, got.count, got.row_end);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                    begin
                        $display("mismatch on result %0d (exp/got): inside %0d/%0d glyph %0d/%0d",
                                 results_seen, want.is_inside, got.is_inside, want.glyph,
                                 got.glyph);
                        $display("    colour %0d/%0d count %0d/%0d end %0d/%0d",
                                 want.colour, got.colour, want.count, got.count,
                                 want.row_end, got.row_end);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("mandelbrot_escape_pixel_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic                  cfg_open;
        logic [CFG_DATA_W-1:0] data;
        logic [CNT_W-1:0]      dim;
        logic [POS_W-1:0]      r;
        logic [POS_W-1:0]      c;
        int                    rows;
        int                    cols;
        int                    sel;
        cfg_open = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == STEP_REG)
            begin
                if (!cfg_open)
                    drain_results();
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_pixel(PLAN[i].row, PLAN[i].column, PLAN[i].typed, PLAN[i].result);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            for (int idx = 0; idx <= int'(CFG_SPARE_INDEX); idx++)
            begin
                data = CFG_DATA_W'($urandom);
                case (idx)
                    CFG_ROW_COUNT, CFG_COLUMN_COUNT:
                    begin
                        case ($urandom_range(0, 9))
                            0: dim = '0;
                            1: dim = CNT_W'($urandom_range(MAX_DIM + 1, 2047));
                            2: dim = CNT_W'($urandom_range(1, 8));
                            default: dim = CNT_W'($urandom_range(1, MAX_DIM));
                        endcase
                        data[CNT_W-1:0] = dim;
                    end
                    CFG_ITERATION_LIMIT:
                    begin
                        // keep most limits short; inside points run the whole limit
                        sel = $urandom_range(0, 8);
                        if (sel < 6)
                            data = CFG_DATA_W'($urandom_range(0, 40));
                        else if (sel < 8)
                            data = CFG_DATA_W'($urandom_range(41, 300));
                        else
                            data = CFG_DATA_W'($urandom_range(301, 1500));
                    end
                    default: ;
                endcase
                write_reg(CFG_IDX_W'(idx), data);
            end
            cfg_valid <= 1'b0;
            rows = effective_count(row_count_q);
            cols = effective_count(column_count_q);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sel = $urandom_range(0, 7);
                if (sel == 0)
                begin
                    r = POS_W'($urandom);
                    c = POS_W'($urandom);
                end
                else
                begin
                    r = POS_W'($urandom_range(0, rows - 1));
                    c = (sel == 1) ? POS_W'(cols - 1) : POS_W'($urandom_range(0, cols - 1));
                end
                send_pixel(r, c, 1'b0, NO_CHECK);
            end
        end

        drain_results();
        $display("%0d pixels sent, %0d results checked, %0d inside, deepest count %0d",
                 items_sent, results_seen, inside_seen, deepest_count);
        $display("%0d register writes over the directed sweep and %0d random settings",
                 reg_writes, PHASES);
        if (bad_results == 0 && pending_pixels.size() == 0)
            $display("mandelbrot_escape_pixel_core verification clean");
        else
            $display("mandelbrot_escape_pixel_core verification failed");
        $finish;
    end

endmodule
